FILE: sv/gac_pkg.sv
// Shared types, constants and helpers for the glyph atlas cache.
`timescale 1ns / 1ps
package gac_pkg;

  localparam int CoordW = 12;
  localparam int SizeW  = 9;
  localparam int AtlasW = 13;

  // Configuration register indexes
  localparam logic [1:0] CFG_CELL_W  = 2'd0;
  localparam logic [1:0] CFG_CELL_H  = 2'd1;
  localparam logic [1:0] CFG_ATLAS_W = 2'd2;
  localparam logic [1:0] CFG_ATLAS_H = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
  } geom_t;

  typedef struct packed {
    logic  placed;
    geom_t geom;
    logic  draw;
  } result_t;

  // Free cursor as seen by the sequencer
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              vacant;
  } cursor_t;

  // Clamp a cell pitch to 1..256
  function automatic logic [SizeW-1:0] clamp_pitch(logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(256)) r = SizeW'(256);
    return r;
  endfunction

  // Clamp an atlas dimension to 1..4096
  function automatic logic [AtlasW-1:0] clamp_atlas(logic [AtlasW-1:0] v);
    logic [AtlasW-1:0] r;
    r = v;
    if (v == '0) r = AtlasW'(1);
    else if (v > AtlasW'(4096)) r = AtlasW'(4096);
    return r;
  endfunction

endpackage

FILE: sv/gac_store.sv
// Code map, entry data and recency link memories.
`timescale 1ns / 1ps
module gac_store
  import gac_pkg::*;
#(
  parameter int MAX_CELLS = 4096,
  parameter int CODE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          map_rd_en,
  input  logic [CODE_BITS-1:0]          map_rd_addr,
  output logic [$clog2(MAX_CELLS)-1:0]  map_rd_data,
  input  logic                          map_wr_en,
  input  logic [CODE_BITS-1:0]          map_wr_addr,
  input  logic [$clog2(MAX_CELLS)-1:0]  map_wr_data,
  input  logic                          ent_rd_en,
  input  logic [$clog2(MAX_CELLS)-1:0]  ent_rd_addr,
  output logic [CODE_BITS-1:0]          ent_rd_code,
  output geom_t                         ent_rd_geom,
  output logic [$clog2(MAX_CELLS)-1:0]  prv_rd_data,
  output logic [$clog2(MAX_CELLS)-1:0]  nxt_rd_data,
  input  logic                          ent_wr_en,
  input  logic [$clog2(MAX_CELLS)-1:0]  ent_wr_addr,
  input  logic [CODE_BITS-1:0]          ent_wr_code,
  input  geom_t                         ent_wr_geom,
  input  logic                          prv_wr_en,
  input  logic [$clog2(MAX_CELLS)-1:0]  prv_wr_addr,
  input  logic [$clog2(MAX_CELLS)-1:0]  prv_wr_data,
  input  logic                          nxt_wr_en,
  input  logic [$clog2(MAX_CELLS)-1:0]  nxt_wr_addr,
  input  logic [$clog2(MAX_CELLS)-1:0]  nxt_wr_data
);

  localparam int IW = $clog2(MAX_CELLS);

  logic [IW-1:0]                       map_mem  [2**CODE_BITS];
  logic [CODE_BITS+$bits(geom_t)-1:0]  ent_mem  [MAX_CELLS];
  logic [IW-1:0]                       prv_mem  [MAX_CELLS];
  logic [IW-1:0]                       nxt_mem  [MAX_CELLS];

  // Code to entry map
  always_ff @(posedge clk) begin
    if (map_wr_en) map_mem[map_wr_addr] <= map_wr_data;
    if (map_rd_en) map_rd_data <= map_mem[map_rd_addr];
  end

  // Entry tag and geometry
  always_ff @(posedge clk) begin
    if (ent_wr_en) ent_mem[ent_wr_addr] <= {ent_wr_code, ent_wr_geom};
    if (ent_rd_en) {ent_rd_code, ent_rd_geom} <= ent_mem[ent_rd_addr];
  end

  // Backward links
  always_ff @(posedge clk) begin
    if (prv_wr_en) prv_mem[prv_wr_addr] <= prv_wr_data;
    if (ent_rd_en) prv_rd_data <= prv_mem[ent_rd_addr];
  end

  // Forward links
  always_ff @(posedge clk) begin
    if (nxt_wr_en) nxt_mem[nxt_wr_addr] <= nxt_wr_data;
    if (ent_rd_en) nxt_rd_data <= nxt_mem[ent_rd_addr];
  end

endmodule

FILE: sv/gac_alloc.sv
// Configuration registers and the free cell cursor of the atlas.
`timescale 1ns / 1ps
module gac_alloc
  import gac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [AtlasW-1:0] cfg_data,
  input  logic              advance,
  input  logic              now_full,
  input  logic              exhaust,
  output cursor_t           cursor
);

  logic [SizeW-1:0]  cell_w, cell_h;
  logic [AtlasW-1:0] atlas_w, atlas_h;
  logic [SizeW-1:0]  cw, ch;
  logic [AtlasW-1:0] aw, ah;
  logic [13:0]       nx, ny;
  logic              wrap, y_over;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_w  <= SizeW'(16);
      cell_h  <= SizeW'(16);
      atlas_w <= AtlasW'(1024);
      atlas_h <= AtlasW'(1024);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CELL_W:  cell_w  <= cfg_data[SizeW-1:0];
        CFG_CELL_H:  cell_h  <= cfg_data[SizeW-1:0];
        CFG_ATLAS_W: atlas_w <= cfg_data;
        CFG_ATLAS_H: atlas_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step the cursor one cell right, wrapping to the next row
  always_comb begin
    cw     = clamp_pitch(cell_w);
    ch     = clamp_pitch(cell_h);
    aw     = clamp_atlas(atlas_w);
    ah     = clamp_atlas(atlas_h);
    nx     = {2'b0, cursor.x} + {5'b0, cw};
    ny     = {2'b0, cursor.y} + {5'b0, ch};
    wrap   = ({1'b0, nx} + {6'b0, cw}) > {2'b0, aw};
    y_over = ({1'b0, ny} + {6'b0, ch}) > {2'b0, ah};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor.x      <= '0;
      cursor.y      <= '0;
      cursor.vacant <= 1'b1;
    end else if (advance) begin
      if (wrap) begin
        cursor.x <= '0;
        cursor.y <= ny[CoordW-1:0];
        if (y_over) cursor.vacant <= 1'b0;
      end else begin
        cursor.x <= nx[CoordW-1:0];
      end
      if (now_full) cursor.vacant <= 1'b0;
    end else if (exhaust) begin
      cursor.vacant <= 1'b0;
    end
  end

endmodule

FILE: sv/glyph_atlas_lru_cache.sv
// Top level: request sequencer of the LRU glyph atlas cache.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid / in_stall | mode, glyph_code, glyph_width, glyph_height
//   out      | out_valid/out_stall | placed, cell_x, cell_y, stored_width,
//            |                     | stored_height, needs_draw
//   cfg      | cfg_write           | cfg_index, cfg_data
//
// One request at a time. A frame end goes straight to the output; any other
// request reads the code map and then the entry memories, an eviction reads
// the tail entry as well, and a hit or eviction off the head entry then
// unlinks it and relinks it in front of the head.
// Reset is synchronous; no memory needs clearing, as the entry count and tag
// check cover unwritten entries. A finished result sits in the output register
// while the next request is taken; a stalled result holds the sequencer only
// when a second result is ready behind it.
`timescale 1ns / 1ps
module glyph_atlas_lru_cache
  import gac_pkg::*;
#(
  parameter int MAX_CELLS = 4096,
  parameter int CODE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [AtlasW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [15:0]       glyph_code,
  input  logic [SizeW-1:0]  glyph_width,
  input  logic [SizeW-1:0]  glyph_height,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              placed,
  output logic [CoordW-1:0] cell_x,
  output logic [CoordW-1:0] cell_y,
  output logic [SizeW-1:0]  stored_width,
  output logic [SizeW-1:0]  stored_height,
  output logic              needs_draw
);

  localparam int IW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAG  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_EVC  = 3'd3;
  localparam logic [2:0] S_W1   = 3'd4;
  localparam logic [2:0] S_W2   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]           state, state_next;
  logic [CODE_BITS-1:0] code;
  logic [SizeW-1:0]     gw, gh;
  logic [IW-1:0]        ent, ent_next;
  logic [IW-1:0]        head, head_next, tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        oldest, oldest_next;
  logic                 in_use, in_use_next;
  logic [IW-1:0]        p_link, p_link_next, n_link, n_link_next;
  result_t              res, res_next;

  logic                 accept;
  logic [IW-1:0]        map_q, prv_q, nxt_q;
  logic [CODE_BITS-1:0] ent_code_q;
  geom_t                ent_geom_q;
  logic                 ent_rd_en;
  logic [IW-1:0]        ent_rd_addr;
  logic                 map_wr_en, ent_wr_en, prv_wr_en, nxt_wr_en;
  logic [IW-1:0]        wr_ent, prv_wr_addr, prv_wr_data, nxt_wr_addr, nxt_wr_data;
  geom_t                ent_wr_geom;
  logic                 advance, now_full, exhaust;
  cursor_t              cursor;
  logic                 hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  gac_store #(.MAX_CELLS(MAX_CELLS), .CODE_BITS(CODE_BITS)) u_store (
    .clk         (clk),
    .map_rd_en   (accept),
    .map_rd_addr (glyph_code[CODE_BITS-1:0]),
    .map_rd_data (map_q),
    .map_wr_en   (map_wr_en),
    .map_wr_addr (code),
    .map_wr_data (wr_ent),
    .ent_rd_en   (ent_rd_en),
    .ent_rd_addr (ent_rd_addr),
    .ent_rd_code (ent_code_q),
    .ent_rd_geom (ent_geom_q),
    .prv_rd_data (prv_q),
    .nxt_rd_data (nxt_q),
    .ent_wr_en   (ent_wr_en),
    .ent_wr_addr (wr_ent),
    .ent_wr_code (code),
    .ent_wr_geom (ent_wr_geom),
    .prv_wr_en   (prv_wr_en),
    .prv_wr_addr (prv_wr_addr),
    .prv_wr_data (prv_wr_data),
    .nxt_wr_en   (nxt_wr_en),
    .nxt_wr_addr (nxt_wr_addr),
    .nxt_wr_data (nxt_wr_data)
  );

  gac_alloc u_alloc (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .now_full  (now_full),
    .exhaust   (exhaust),
    .cursor    (cursor)
  );

  assign hit = (CW'(ent) < count) && (ent_code_q == code);

  // Sequence one request through map read, tag check, placement or eviction, and relinking
  always_comb begin
    state_next  = state;
    ent_next    = ent;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    oldest_next = oldest;
    in_use_next = in_use;
    p_link_next = p_link;
    n_link_next = n_link;
    res_next    = res;
    ent_rd_en   = 1'b0;
    ent_rd_addr = tail;
    map_wr_en   = 1'b0;
    ent_wr_en   = 1'b0;
    prv_wr_en   = 1'b0;
    nxt_wr_en   = 1'b0;
    wr_ent      = ent;
    ent_wr_geom = ent_geom_q;
    prv_wr_addr = head;
    prv_wr_data = ent;
    nxt_wr_addr = ent;
    nxt_wr_data = head;
    advance     = 1'b0;
    now_full    = 1'b0;
    exhaust     = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next = '0;
          if (mode) begin
            in_use_next = 1'b0;
            state_next  = S_OUT;
          end else begin
            state_next = S_TAG;
          end
        end
      end

      S_TAG: begin
        ent_rd_en   = 1'b1;
        ent_rd_addr = map_q;
        ent_next    = map_q;
        state_next  = S_CHK;
      end

      S_CHK: begin
        if (hit) begin
          if (!in_use) begin
            oldest_next = ent;
            in_use_next = 1'b1;
          end else if (oldest == ent && head != ent) begin
            oldest_next = prv_q;
          end
          res_next = '{placed: 1'b1, geom: ent_geom_q, draw: 1'b0};
          p_link_next = prv_q;
          n_link_next = nxt_q;
          state_next  = (ent == head) ? S_OUT : S_W1;
        end else if (cursor.vacant && count < CW'(MAX_CELLS)) begin
          // Place into the next free cell
          wr_ent      = count[IW-1:0];
          ent_next    = count[IW-1:0];
          ent_wr_geom = '{x: cursor.x, y: cursor.y, w: gw, h: gh};
          ent_wr_en   = 1'b1;
          map_wr_en   = 1'b1;
          if (count == '0) begin
            tail_next = count[IW-1:0];
          end else begin
            nxt_wr_en   = 1'b1;
            nxt_wr_addr = count[IW-1:0];
            prv_wr_en   = 1'b1;
            prv_wr_data = count[IW-1:0];
          end
          head_next  = count[IW-1:0];
          count_next = count + CW'(1);
          if (!in_use) begin
            oldest_next = count[IW-1:0];
            in_use_next = 1'b1;
          end
          advance  = 1'b1;
          now_full = (count + CW'(1)) >= CW'(MAX_CELLS);
          res_next = '{placed: 1'b1, geom: ent_wr_geom, draw: 1'b1};
          state_next = S_OUT;
        end else begin
          exhaust = 1'b1;
          if (count == '0 || (in_use && oldest == tail)) begin
            state_next = S_OUT;
          end else begin
            // Fetch the tail for reuse
            ent_rd_en   = 1'b1;
            ent_rd_addr = tail;
            ent_next    = tail;
            state_next  = S_EVC;
          end
        end
      end

      S_EVC: begin
        ent_wr_geom = '{x: ent_geom_q.x, y: ent_geom_q.y, w: gw, h: gh};
        ent_wr_en   = 1'b1;
        map_wr_en   = 1'b1;
        if (!in_use) begin
          oldest_next = ent;
          in_use_next = 1'b1;
        end
        res_next    = '{placed: 1'b1, geom: ent_wr_geom, draw: 1'b1};
        p_link_next = prv_q;
        n_link_next = nxt_q;
        state_next  = (ent == head) ? S_OUT : S_W1;
      end

      S_W1: begin
        // Unlink the entry from its neighbors
        nxt_wr_en   = 1'b1;
        nxt_wr_addr = p_link;
        nxt_wr_data = n_link;
        if (ent == tail) begin
          tail_next = p_link;
        end else begin
          prv_wr_en   = 1'b1;
          prv_wr_addr = n_link;
          prv_wr_data = p_link;
        end
        state_next = S_W2;
      end

      S_W2: begin
        // Link the entry in front of the head
        nxt_wr_en  = 1'b1;
        prv_wr_en  = 1'b1;
        head_next  = ent;
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      oldest <= '0;
      in_use <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      oldest <= oldest_next;
      in_use <= in_use_next;
    end
  end

  // Hold the request payload and working values
  always_ff @(posedge clk) begin
    if (accept) begin
      code <= glyph_code[CODE_BITS-1:0];
      gw   <= glyph_width;
      gh   <= glyph_height;
    end
    ent    <= ent_next;
    p_link <= p_link_next;
    n_link <= n_link_next;
    res    <= res_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      placed        <= res.placed;
      cell_x        <= res.geom.x;
      cell_y        <= res.geom.y;
      stored_width  <= res.geom.w;
      stored_height <= res.geom.h;
      needs_draw    <= res.draw;
    end
  end

endmodule
